// ===== hw/rtl/lpht_pkg.sv =====
package lpht_pkg;

   // Slot store geometry
   localparam int SLOT_COUNT = 1024;
   localparam int KEY_WIDTH  = 32;
   localparam int INDEX_W    = $clog2(SLOT_COUNT);
   localparam int SIZE_W     = $clog2(SLOT_COUNT + 1);
   localparam int ENTRY_W    = KEY_WIDTH + 1;

   // Fixed field widths of the channels
   localparam int KEY_IN_W    = 32;
   localparam int HASH_W      = 32;
   localparam int CFG_W       = 11;
   localparam int OUT_INDEX_W = 10;

   localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = CFG_W'(1024);

   // Modulo unit: quotient bits retired per cycle
   localparam int MOD_STEP_BITS = 4;
   localparam int MOD_CYCLES    = HASH_W / MOD_STEP_BITS;
   localparam int MOD_CNT_W     = $clog2(MOD_CYCLES);

   localparam logic OP_FIND     = 1'b0;
   localparam logic OP_INSERT   = 1'b1;
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef struct packed {
      logic              done;
      logic [SIZE_W-1:0] rem;
   } lpht_mod_rsp_type;

   // Clamp the configured size into 1..SLOT_COUNT
   function automatic logic [SIZE_W-1:0] size_in_use(input logic [CFG_W-1:0] cfg);
      logic [31:0] s;
      s = 32'(cfg);
      if (s == 32'd0) begin
         s = 32'd1;
      end
      if (s > 32'(SLOT_COUNT)) begin
         s = 32'(SLOT_COUNT);
      end
      return SIZE_W'(s);
   endfunction

endpackage

// ===== hw/rtl/lpht_if.sv =====
interface lpht_req_if import lpht_pkg::*;;
   logic                valid;
   logic                ready;
   logic                op;
   logic [KEY_IN_W-1:0] key;
   logic [HASH_W-1:0]   hash_value;

   modport source (output valid, output op, output key, output hash_value, input ready);
   modport sink   (input valid, input op, input key, input hash_value, output ready);
endinterface

interface lpht_rsp_if import lpht_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic                   status;
   logic [OUT_INDEX_W-1:0] slot_index;

   modport source (output valid, output status, output slot_index, input ready);
   modport sink   (input valid, input status, input slot_index, output ready);
endinterface

interface lpht_csr_if import lpht_pkg::*;;
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] table_size;

   modport source (output valid, output table_size, input ready);
   modport sink   (input valid, input table_size, output ready);
endinterface

// ===== hw/rtl/linear_probe_hash_table.sv =====
// Channel  Direction  Payload                    Transfer
// req      in         op, key, hash_value        valid & ready
// rsp      out        status, slot_index         valid & ready
// csr      in         table_size                 valid & ready (ready always high)
//
// After reset a clearing pass writes every slot empty with req ready low;
// table_size writes are taken throughout.
// A transaction runs through an accept step, the modulo unit (steps of four
// remainder bits, then presenting the remainder), the launch of the first slot
// read, one read per probed slot, and the load of rsp.
// A stalled rsp holds its register; the next request is taken while it waits.
module linear_probe_hash_table import lpht_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   lpht_req_if.sink    req_chan,
   lpht_rsp_if.source  rsp_chan,
   lpht_csr_if.sink    csr_chan
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MOD   = 3'd2;
   localparam logic [2:0] ST_PROBE = 3'd3;
   localparam logic [2:0] ST_RESP  = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [CFG_W-1:0]       table_size_ff, table_size_in;
   logic [INDEX_W-1:0]     clr_ff, clr_in;
   logic                   op_ff, op_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [SIZE_W-1:0]      size_ff, size_in;
   logic [INDEX_W-1:0]     rd_pos_ff, rd_pos_in;
   logic [INDEX_W-1:0]     chk_pos_ff, chk_pos_in;
   logic                   chk_valid_ff, chk_valid_in;
   logic [SIZE_W-1:0]      visit_ff, visit_in;
   logic                   res_ok_ff, res_ok_in;
   logic [INDEX_W-1:0]     res_pos_ff, res_pos_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_status_ff, rsp_status_in;
   logic [OUT_INDEX_W-1:0] rsp_index_ff, rsp_index_in;

   logic                   req_fire;
   logic [SIZE_W-1:0]      cfg_size;
   lpht_mod_rsp_type       mod_rsp;

   logic                   ram_wr_en;
   logic [INDEX_W-1:0]     ram_wr_addr;
   logic [ENTRY_W-1:0]     ram_wr_data;
   logic                   ram_rd_en;
   logic [ENTRY_W-1:0]     ram_rd_data;

   logic                   slot_used;
   logic [KEY_WIDTH-1:0]   slot_key;
   logic [SIZE_W-1:0]      rd_pos_inc;
   logic [SIZE_W-1:0]      visit_inc;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid & req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign cfg_size       = size_in_use(table_size_ff);

   // Home slot = hash_value mod size, computed iteratively
   lpht_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (req_fire),
      .dividend (req_chan.hash_value),
      .divisor  (cfg_size),
      .result   (mod_rsp)
   );

   // Slot store: {used, key} per entry, one read and one write port
   lpht_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOT_COUNT)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_pos_ff),
      .rd_data (ram_rd_data)
   );

   assign slot_used  = ram_rd_data[KEY_WIDTH];
   assign slot_key   = ram_rd_data[KEY_WIDTH-1:0];
   assign rd_pos_inc = SIZE_W'(rd_pos_ff) + 1'b1;
   assign visit_inc  = visit_ff + 1'b1;
   assign ram_rd_en  = (state_ff == ST_PROBE);

   always_comb begin
      state_in      = state_ff;
      table_size_in = table_size_ff;
      clr_in        = clr_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      size_in       = size_ff;
      rd_pos_in     = rd_pos_ff;
      chk_pos_in    = chk_pos_ff;
      chk_valid_in  = chk_valid_ff;
      visit_in      = visit_ff;
      res_ok_in     = res_ok_ff;
      res_pos_in    = res_pos_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = clr_ff;
      ram_wr_data   = '0;

      if (csr_chan.valid) begin
         table_size_in = csr_chan.table_size;
      end

      // Drop the result once the sink takes it
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            // Write every slot empty, one per cycle
            ram_wr_en = 1'b1;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == INDEX_W'(SLOT_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_chan.op;
               key_in   = KEY_WIDTH'(req_chan.key);
               size_in  = cfg_size;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (mod_rsp.done) begin
               rd_pos_in    = mod_rsp.rem[INDEX_W-1:0];
               chk_valid_in = 1'b0;
               visit_in     = '0;
               state_in     = ST_PROBE;
            end
         end
         ST_PROBE: begin
            // Launch the next slot read every cycle; the data for the slot
            // checked now came from the read launched in the previous cycle
            rd_pos_in    = (rd_pos_inc == size_ff) ? '0 : rd_pos_inc[INDEX_W-1:0];
            chk_pos_in   = rd_pos_ff;
            chk_valid_in = 1'b1;
            if (chk_valid_ff) begin
               res_pos_in = chk_pos_ff;
               if (!slot_used) begin
                  // Empty slot ends the walk; an insert claims it
                  res_ok_in = (op_ff == OP_INSERT);
                  state_in  = ST_RESP;
                  if (op_ff == OP_INSERT) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = chk_pos_ff;
                     ram_wr_data = {1'b1, key_ff};
                  end
               end else if (op_ff == OP_FIND && slot_key == key_ff) begin
                  res_ok_in = 1'b1;
                  state_in  = ST_RESP;
               end else if (visit_inc == size_ff) begin
                  // Every slot in use visited: full table or missing key
                  res_ok_in = 1'b0;
                  state_in  = ST_RESP;
               end else begin
                  visit_in = visit_inc;
               end
            end
         end
         ST_RESP: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_ok_ff ? STATUS_OK : STATUS_FAIL;
               rsp_index_in  = res_ok_ff ? OUT_INDEX_W'(res_pos_ff) : '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         table_size_ff <= TABLE_SIZE_RESET;
         clr_ff        <= '0;
         chk_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         table_size_ff <= table_size_in;
         clr_ff        <= clr_in;
         chk_valid_ff  <= chk_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      size_ff       <= size_in;
      rd_pos_ff     <= rd_pos_in;
      chk_pos_ff    <= chk_pos_in;
      visit_ff      <= visit_in;
      res_ok_ff     <= res_ok_in;
      res_pos_ff    <= res_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.slot_index = rsp_index_ff;

endmodule

// ===== hw/rtl/lpht_ram.sv =====
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/lpht_mod.sv =====
module lpht_mod import lpht_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [HASH_W-1:0] dividend,
   input  logic [SIZE_W-1:0] divisor,
   output lpht_mod_rsp_type  result
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic [HASH_W-1:0]    num_ff, num_in;
   logic [SIZE_W-1:0]    div_ff, div_in;
   logic [SIZE_W-1:0]    rem_ff, rem_in;

   // Restoring remainder, MOD_STEP_BITS dividend bits per cycle
   always_comb begin
      logic [SIZE_W:0]   r;
      logic [HASH_W-1:0] n;
      r = {1'b0, rem_ff};
      n = num_ff;
      for (int i = 0; i < MOD_STEP_BITS; i++) begin
         r = {r[SIZE_W-1:0], n[HASH_W-1]};
         n = {n[HASH_W-2:0], 1'b0};
         if (r >= {1'b0, div_ff}) begin
            r = r - {1'b0, div_ff};
         end
      end

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         num_in = n;
         rem_in = r[SIZE_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MOD_CNT_W'(MOD_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign result.done = done_ff;
   assign result.rem  = rem_ff;

endmodule

// ===== hw/rtl/lpht_chk.sv =====
module lpht_chk import lpht_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_status,
   input logic [OUT_INDEX_W-1:0] rsp_slot_index
);

   // A stalled result holds its payload
   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot_index))
      else $error("rsp changed while stalled");

   // A failed transaction reports slot zero
   fail_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FAIL |-> rsp_slot_index == '0)
      else $error("failure with nonzero slot index");

   // One request in flight: ready drops after an accept
   one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

   // Clearing pass follows reset
   clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");

endmodule

bind linear_probe_hash_table lpht_chk u_lpht_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_slot_index (rsp_chan.slot_index)
);

// ===== tb/tb_linear_probe_hash_table.sv =====
`timescale 1ns / 1ps

module tb_linear_probe_hash_table;
   import lpht_pkg::*;

   // Cycles without any transaction on any channel before the run is called hung.
   // Covers the clearing pass, a full-table probe and the long receiver hold-off,
   // with plenty of margin.
   localparam int STALL_LIMIT    = 20000;
   localparam int HOLD_CYCLES    = 400;
   localparam int TAIL_CYCLES    = 100;
   localparam int PHASE_ITEMS    = 82;
   localparam int KEY_POOL_SIZE  = 12;
   localparam int REMEMBER_DEPTH = 256;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic                   status;
      logic [OUT_INDEX_W-1:0] slot;
   } probe_result_type;

   // Mirror of the slot store plus the queue of results still owed by the block.
   class hash_slot_mirror_type;
      logic                 used [SLOT_COUNT];
      logic [KEY_WIDTH-1:0] stored_key [SLOT_COUNT];
      logic [CFG_W-1:0]     size_reg;
      probe_result_type     expected_results [$];
      int                   mismatch_count;

      function new();
         size_reg = TABLE_SIZE_RESET;
         mismatch_count = 0;
         foreach (used[i]) begin
            used[i] = 1'b0;
            stored_key[i] = '0;
         end
      endfunction

      function void set_table_size(input logic [CFG_W-1:0] value);
         size_reg = value;
      endfunction

      // Walk the probe path exactly as the block should and queue the outcome.
      function void note_request(input logic op, input logic [KEY_IN_W-1:0] key,
                                 input logic [HASH_W-1:0] hash_value);
         int unsigned   span;
         int unsigned   pos;
         int unsigned   n;
         logic [KEY_WIDTH-1:0] k;
         probe_result_type res;
         span = size_reg;
         if (span == 0) span = 1;
         if (span > SLOT_COUNT) span = SLOT_COUNT;
         k = KEY_WIDTH'(key);
         pos = hash_value % span;
         res.status = STATUS_FAIL;
         res.slot = '0;
         for (n = 0; n < span; n++) begin
            if (!used[pos]) begin
               if (op == OP_INSERT) begin
                  used[pos] = 1'b1;
                  stored_key[pos] = k;
                  res.status = STATUS_OK;
                  res.slot = OUT_INDEX_W'(pos);
               end
               break;
            end
            if (op == OP_FIND && stored_key[pos] == k) begin
               res.status = STATUS_OK;
               res.slot = OUT_INDEX_W'(pos);
               break;
            end
            pos = (pos + 1 == span) ? 0 : pos + 1;
         end
         expected_results.push_back(res);
      endfunction

      function void check_response(input logic status, input logic [OUT_INDEX_W-1:0] slot);
         probe_result_type want;
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected response: status %0d slot %0d", status, slot);
            return;
         end
         want = expected_results.pop_front();
         if (status !== want.status || slot !== want.slot) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("response mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                        want.status, want.slot, status, slot);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   lpht_req_if req_chan ();
   lpht_rsp_if rsp_chan ();
   lpht_csr_if csr_chan ();

   linear_probe_hash_table uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #10 clock = ~clock;

   hash_slot_mirror_type mirror;

   // Shared knobs: random idling on both sides, and a counter the stimulus bumps
   // to ask the receiver for one long hold-off.
   bit idling_on = 1'b1;
   int hold_requests = 0;
   int quiet_cycles = 0;

   logic [KEY_IN_W-1:0] key_pool [KEY_POOL_SIZE];
   logic [KEY_IN_W-1:0] stored_keys [$];
   logic [HASH_W-1:0]   stored_hashes [$];

   // Response side: check each accepted transaction, then pick next ready.
   initial begin : rsp_side
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready)
            mirror.check_response(rsp_chan.status, rsp_chan.slot_index);
         // Load a fresh hold-off when the stimulus asks for one.
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= !(idling_on && $urandom_range(99) < 11);
         end
      end
   end

   // Watchdog: end the run if no channel moves a transaction for too long.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Offer one request and hold it until taken. Valid is only dropped across
   // an idle gap, so a back-to-back request never lowers and raises it in one step.
   task automatic send_request(input logic op, input logic [KEY_IN_W-1:0] key,
                               input logic [HASH_W-1:0] hash_value);
      int idle;
      idle = 0;
      while (idling_on && $urandom_range(99) < 11) idle++;
      if (idle > 0) begin
         req_chan.valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.op         <= op;
      req_chan.key        <= key;
      req_chan.hash_value <= hash_value;
      do @(posedge clock); while (!req_chan.ready);
      mirror.note_request(op, key, hash_value);
   endtask

   // Drop valid and wait until every owed response has been taken.
   // It always waits for a clock edge before checking the queue.
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (mirror.expected_results.size() != 0) @(posedge clock);
   endtask

   // Write table_size only once the block has drained.
   task automatic write_table_size(input logic [CFG_W-1:0] size_value);
      wait_for_results();
      csr_chan.valid      <= 1'b1;
      csr_chan.table_size <= size_value;
      do @(posedge clock); while (!csr_chan.ready);
      mirror.set_table_size(size_value);
      csr_chan.valid <= 1'b0;
   endtask

   // Mostly well-formed traffic: inserts from a small key pool (so duplicates
   // and key matches deep in probe runs are common) and finds that reuse an
   // inserted key with its hash; the rest is random noise.
   task automatic send_random_request();
      logic                op;
      logic [KEY_IN_W-1:0] key;
      logic [HASH_W-1:0]   hash_value;
      int                  roll;
      int                  pick;
      roll = $urandom_range(99);
      key = $urandom;
      hash_value = $urandom;
      if (roll < 45) begin
         op = OP_INSERT;
         if ($urandom_range(99) < 70)
            key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
         if (stored_keys.size() >= REMEMBER_DEPTH) begin
            void'(stored_keys.pop_front());
            void'(stored_hashes.pop_front());
         end
         stored_keys.push_back(key);
         stored_hashes.push_back(hash_value);
      end else begin
         op = OP_FIND;
         if (stored_keys.size() > 0 && roll < 85) begin
            pick = $urandom_range(stored_keys.size() - 1);
            key = stored_keys[pick];
            if (roll < 75)
               hash_value = stored_hashes[pick];
         end
      end
      send_request(op, key, hash_value);
   endtask

   initial begin : stimulus
      logic [CFG_W-1:0] phase_sizes [12];
      int p;
      int i;
      mirror = new();
      phase_sizes = '{11'd1, 11'd2, 11'd1025, 11'd7, 11'd1024, 11'd64,
                      11'd2, 11'd1023, 11'd37, 11'd513, 11'd5, 11'd300};
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;

      // Hold reset and drive every input to a known value.
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.op         <= OP_FIND;
      req_chan.key        <= '0;
      req_chan.hash_value <= '0;
      csr_chan.valid      <= 1'b0;
      csr_chan.table_size <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset size 1024. The first request also waits out the clearing pass.
      send_request(OP_INSERT, 32'h0000_0000, 32'h0000_0000);  // home slot 0
      send_request(OP_INSERT, 32'h0000_0000, 32'h0000_0000);  // duplicate key -> slot 1
      send_request(OP_FIND,   32'h0000_0000, 32'h0000_0000);  // first copy found
      send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // top slot 1023
      send_request(OP_INSERT, 32'h5A5A_A5A5, 32'hFFFF_FFFF);  // wraps past 0 and 1 -> slot 2
      send_request(OP_FIND,   32'h5A5A_A5A5, 32'hFFFF_FFFF);  // find across the wrap
      send_request(OP_FIND,   32'h0000_0123, 32'h0000_0003);  // empty slot: not found
      send_request(OP_FIND,   32'hFFFF_FFFF, 32'h4000_03FF);  // high hash bits reduced away

      // Size zero behaves as a single slot, already filled.
      write_table_size(11'd0);
      send_request(OP_FIND,   32'h0000_0000, 32'h8000_0000);
      send_request(OP_INSERT, 32'h0000_0077, 32'h0000_0001);  // table full
      send_request(OP_FIND,   32'h0000_0077, 32'h0000_0001);  // full wrap, not found

      // Oversized setting saturates to the whole store.
      write_table_size(11'd2047);
      send_request(OP_FIND,   32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // Shrink: slots 0..2 full, slot 1023 is left outside the probed range.
      write_table_size(11'd3);
      send_request(OP_INSERT, 32'h1234_5678, 32'h0000_0005);  // table full
      send_request(OP_FIND,   32'h0000_0000, 32'h0000_0002);  // wraps 2 -> 0
      send_request(OP_FIND,   32'hDEAD_BEEF, 32'h0000_0001);  // full wrap, not found
      send_request(OP_FIND,   32'hFFFF_FFFF, 32'hFFFF_FFFF);  // stale slot not probed

      // Random phases, one table size each; the store carries over between them.
      for (p = 0; p < 12; p++) begin
         write_table_size(phase_sizes[p]);
         idling_on = (p != 4);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            // Back-pressure the response side while requests keep coming.
            if (p == 1 && i == 10) hold_requests++;
            // Pause the sender mid-phase until the block has drained.
            if (p == 6 && i == 40) wait_for_results();
            send_random_request();
         end
      end
      idling_on = 1'b1;

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mirror.mismatch_count == 0 && mirror.expected_results.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== linear_probe_hash_table.f =====
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_if.sv
hw/rtl/lpht_ram.sv
hw/rtl/lpht_mod.sv
hw/rtl/linear_probe_hash_table.sv
hw/rtl/lpht_chk.sv
tb/tb_linear_probe_hash_table.sv
